[src/dpwp_pkg.sv]
`default_nettype none

package dpwp_pkg;

  // Default index widths
  localparam int COL_BITS_DEF = 10;
  localparam int ROW_BITS_DEF = 10;

  // Principal point doubled, so that 2u - CX2 stays integer
  localparam int CX2 = 651;
  localparam int CY2 = 507;

  // x: round(|2u-651| * d * 2048 / 32375)
  localparam int X_DEN  = 32375;
  localparam int X_SH   = 11;
  localparam int X_HALF = 16187;
  // y: round(|2v-507| * d * 4096 / 64875)
  localparam int Y_DEN  = 64875;
  localparam int Y_SH   = 12;
  localparam int Y_HALF = 32437;
  // z: round(d * 8192 / 125)
  localparam int Z_DEN  = 125;
  localparam int Z_SH   = 13;
  localparam int Z_HALF = 62;

  // Reciprocal multipliers, truncated so the estimate is low by 0..2
  localparam int RECIP_SH   = 35;
  localparam int Z_RECIP_SH = 25;
  localparam logic [31:0] X_RECIP = 32'((64'd1 << (RECIP_SH + X_SH)) / X_DEN);
  localparam logic [31:0] Y_RECIP = 32'((64'd1 << (RECIP_SH + Y_SH)) / Y_DEN);
  localparam logic [31:0] Z_RECIP = 32'((64'd1 << (Z_RECIP_SH + Z_SH)) / Z_DEN);

  // Remainder widths: must hold three times the divisor
  localparam int REM_W  = 18;
  localparam int ZREM_W = 9;

  // Rotation matrix, Q2.28 with headroom for any quaternion bits
  localparam int R_W       = 34;
  localparam int Q28_SH    = 28;
  localparam int Q28_ONE   = 1 << 28;
  localparam int Q28_HALF  = 1 << 27;
  localparam int QZ_W      = 23;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z = 3'd6;

  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Stage handoff: valid bit plus the pass-through colour
  typedef struct packed {
    logic   valid;
    color_t color;
  } tag_t;

endpackage

`default_nettype wire

[src/dpwp_backproj.sv]
`default_nettype none

module dpwp_backproj #(
  parameter int COL_BITS = dpwp_pkg::COL_BITS_DEF,
  parameter int ROW_BITS = dpwp_pkg::ROW_BITS_DEF,
  parameter int PC_W     = 25
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic [COL_BITS-1:0]        col,
  input  wire logic [ROW_BITS-1:0]        row,
  input  wire logic [15:0]                depth_mm,
  input  wire dpwp_pkg::color_t           color,
  output dpwp_pkg::tag_t                  tag_o,
  output logic signed [PC_W-1:0]          pc_x,
  output logic signed [PC_W-1:0]          pc_y,
  output logic signed [PC_W-1:0]          pc_z
);
  import dpwp_pkg::*;

  localparam int AX_W = (COL_BITS + 1 > 10) ? COL_BITS + 1 : 10;
  localparam int AY_W = (ROW_BITS + 1 > 9) ? ROW_BITS + 1 : 9;
  localparam int PA_W = AX_W + 16;
  localparam int PB_W = AY_W + 16;
  localparam int QX_W = PA_W - 3;
  localparam int QY_W = PB_W - 3;
  localparam int XLO_W = REM_W - X_SH;
  localparam int YLO_W = REM_W - Y_SH;

  // valid and colour per stage
  logic [3:0] vld_r;
  color_t     clr_r [4];

  // Stage 1: offset from principal point, magnitude times depth
  logic signed [AX_W:0]  ax;
  logic signed [AY_W:0]  ay;
  logic [AX_W-1:0]       ax_mag;
  logic [AY_W-1:0]       ay_mag;
  logic [PA_W-1:0]       pa_nxt;
  logic [PB_W-1:0]       pb_nxt;
  logic [PA_W-1:0]       pa_r;
  logic [PB_W-1:0]       pb_r;
  logic [15:0]           d1_r;
  logic [2:0]            sx_r;
  logic [2:0]            sy_r;

  always_comb begin
    ax = $signed({{(AX_W - COL_BITS){1'b0}}, col, 1'b0}) - $signed((AX_W + 1)'(CX2));
    ay = $signed({{(AY_W - ROW_BITS){1'b0}}, row, 1'b0}) - $signed((AY_W + 1)'(CY2));
    ax_mag = ax[AX_W] ? AX_W'(-ax) : AX_W'(ax);
    ay_mag = ay[AY_W] ? AY_W'(-ay) : AY_W'(ay);
    pa_nxt = ax_mag * depth_mm;
    pb_nxt = ay_mag * depth_mm;
  end

  // Stage 2: quotient estimates by reciprocal multiply
  logic [PA_W+31:0]      px;
  logic [PB_W+31:0]      py;
  logic [47:0]           pz;
  logic [QX_W-1:0]       qxe_r;
  logic [QY_W-1:0]       qye_r;
  logic [QZ_W-1:0]       qze_r;
  logic [XLO_W-1:0]      xlo_r;
  logic [YLO_W-1:0]      ylo_r;

  always_comb begin
    px = pa_r * X_RECIP;
    py = pb_r * Y_RECIP;
    pz = d1_r * Z_RECIP;
  end

  // Stage 3: remainder check, estimate raised by 0, 1 or 2
  logic [REM_W-1:0]      rx;
  logic [REM_W-1:0]      ry;
  logic [ZREM_W-1:0]     rz;
  logic [1:0]            cx;
  logic [1:0]            cy;
  logic [1:0]            cz;
  logic [QX_W-1:0]       qx_r;
  logic [QY_W-1:0]       qy_r;
  logic [QZ_W-1:0]       qz_r;

  always_comb begin
    rx = {xlo_r, {X_SH{1'b0}}} + REM_W'(X_HALF)
         - REM_W'(qxe_r[REM_W-1:0] * REM_W'(X_DEN));
    ry = {ylo_r, {Y_SH{1'b0}}} + REM_W'(Y_HALF)
         - REM_W'(qye_r[REM_W-1:0] * REM_W'(Y_DEN));
    // d * 8192 vanishes modulo the short remainder width
    rz = ZREM_W'(Z_HALF) - ZREM_W'(qze_r[ZREM_W-1:0] * ZREM_W'(Z_DEN));
    if (rx >= REM_W'(2 * X_DEN))      cx = 2'd2;
    else if (rx >= REM_W'(X_DEN))     cx = 2'd1;
    else                              cx = 2'd0;
    if (ry >= REM_W'(2 * Y_DEN))      cy = 2'd2;
    else if (ry >= REM_W'(Y_DEN))     cy = 2'd1;
    else                              cy = 2'd0;
    if (rz >= ZREM_W'(2 * Z_DEN))     cz = 2'd2;
    else if (rz >= ZREM_W'(Z_DEN))    cz = 2'd1;
    else                              cz = 2'd0;
  end

  // Stage 4: restore sign
  logic signed [PC_W-1:0] ex;
  logic signed [PC_W-1:0] ey;
  logic signed [PC_W-1:0] pcx_nxt;
  logic signed [PC_W-1:0] pcy_nxt;

  always_comb begin
    ex = $signed(PC_W'(qx_r));
    ey = $signed(PC_W'(qy_r));
    pcx_nxt = sx_r[2] ? -ex : ex;
    pcy_nxt = sy_r[2] ? -ey : ey;
  end

  // Valid bits; zero depth never enters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_valid && (depth_mm != 16'd0)};
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      clr_r[0] <= color;
      clr_r[1] <= clr_r[0];
      clr_r[2] <= clr_r[1];
      clr_r[3] <= clr_r[2];
      sx_r     <= {sx_r[1:0], ax[AX_W]};
      sy_r     <= {sy_r[1:0], ay[AY_W]};

      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      d1_r     <= depth_mm;

      qxe_r    <= px[PA_W+31:RECIP_SH];
      qye_r    <= py[PB_W+31:RECIP_SH];
      qze_r    <= pz[47:Z_RECIP_SH];
      xlo_r    <= pa_r[XLO_W-1:0];
      ylo_r    <= pb_r[YLO_W-1:0];

      qx_r     <= qxe_r + QX_W'(cx);
      qy_r     <= qye_r + QY_W'(cy);
      qz_r     <= qze_r + QZ_W'(cz);

      pc_x     <= pcx_nxt;
      pc_y     <= pcy_nxt;
      pc_z     <= $signed(PC_W'(qz_r));
    end
  end

  assign tag_o.valid = vld_r[3];
  assign tag_o.color = clr_r[3];

endmodule

`default_nettype wire

[src/dpwp_pose.sv]
`default_nettype none

module dpwp_pose #(
  parameter int PC_W = 25
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                adv,
  input  wire dpwp_pkg::tag_t                      tag_i,
  input  wire logic signed [PC_W-1:0]              pc_x,
  input  wire logic signed [PC_W-1:0]              pc_y,
  input  wire logic signed [PC_W-1:0]              pc_z,
  input  wire logic signed [dpwp_pkg::R_W-1:0]     rot [9],
  input  wire logic signed [31:0]                  trans [3],
  output dpwp_pkg::tag_t                           tag_o,
  output logic signed [31:0]                       world [3]
);
  import dpwp_pkg::*;

  localparam int PROD_W = R_W + PC_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SH_W   = SUM_W - Q28_SH;
  localparam int W_W    = ((SH_W > 32) ? SH_W : 32) + 1;

  logic [2:0]             vld_r;
  color_t                 clr_r [3];

  logic signed [PC_W-1:0]   pc [3];
  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [SUM_W-1:0]  sum [3];
  logic signed [SH_W-1:0]   sh_r [3];
  logic signed [W_W-1:0]    w [3];
  logic signed [31:0]       world_nxt [3];

  assign pc[0] = pc_x;
  assign pc[1] = pc_y;
  assign pc[2] = pc_z;

  // Stage 6 input: row sums with half added; floor is the upper bits
  // Stage 7 input: translation and saturation to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'(prod_r[3*i]) + SUM_W'(prod_r[3*i+1]) + SUM_W'(prod_r[3*i+2])
               + SUM_W'(Q28_HALF);
      w[i] = W_W'(sh_r[i]) + W_W'(trans[i]);
      if (&w[i][W_W-1:31] || ~|w[i][W_W-1:31]) begin
        world_nxt[i] = w[i][31:0];
      end else begin
        world_nxt[i] = w[i][W_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], tag_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clr_r[0] <= tag_i.color;
      clr_r[1] <= clr_r[0];
      clr_r[2] <= clr_r[1];
      // Stage 5: matrix entries times camera coordinates
      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= PROD_W'(rot[k]) * PROD_W'(pc[k % 3]);
      end
      for (int i = 0; i < 3; i++) begin
        sh_r[i]  <= sum[i][SUM_W-1:Q28_SH];
        world[i] <= world_nxt[i];
      end
    end
  end

  assign tag_o.valid = vld_r[2];
  assign tag_o.color = clr_r[2];

endmodule

`default_nettype wire

[src/depth_pixel_to_world_point_core.sv]
`default_nettype none

// Back-projects RGB-D pixels through a fixed pinhole camera (cx 325.5,
// cy 253.5, fx 518, fy 519, depth in mm) and moves the point by the pose
// set over the cfg port: a Q1.14 quaternion, used as given without
// normalization, and a Q16.16 translation. Results are Q16.16 metres,
// saturated, with the colour passed through. One pixel is taken per clock
// while the pipeline advances; a result passes the seven register stages
// of the datapath (offset multiply, reciprocal multiply, remainder
// correction, sign, matrix multiply, row sum, translate and saturate).
// Pixels with zero depth give no result and leave a bubble. The whole
// pipeline holds while out_tready is low with a result waiting; in_tready
// follows that condition. The pose, held in the cfg registers and then a
// registered rotation matrix, must only change with the pipeline empty.
module depth_pixel_to_world_point_core #(
  parameter int COL_BITS = dpwp_pkg::COL_BITS_DEF,
  parameter int ROW_BITS = dpwp_pkg::ROW_BITS_DEF,
  localparam int IN_W    = ((COL_BITS + ROW_BITS + 40 + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // lowest bit up: col, row, depth_mm[16], blue[8], green[8], red[8], zero fill
  input  wire logic [IN_W-1:0]                   in_tdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // lowest bit up: world_x[32], world_y[32], world_z[32],
  // out_blue[8], out_green[8], out_red[8]
  output logic [119:0]                           out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [dpwp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_wdata
);
  import dpwp_pkg::*;

  localparam int AX_W = (COL_BITS + 1 > 10) ? COL_BITS + 1 : 10;
  localparam int AY_W = (ROW_BITS + 1 > 9) ? ROW_BITS + 1 : 9;
  localparam int QX_W = AX_W + 13;
  localparam int QY_W = AY_W + 13;
  localparam int QM_W = (QX_W > QY_W) ? QX_W : QY_W;
  localparam int PC_W = ((QM_W > QZ_W) ? QM_W : QZ_W) + 1;
  localparam int DEP_LO = COL_BITS + ROW_BITS;

  // Pipeline advance: output register empty or being taken
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Configuration registers
  logic signed [15:0] qw_r;
  logic signed [15:0] qx_r;
  logic signed [15:0] qy_r;
  logic signed [15:0] qz_r;
  logic signed [31:0] trans_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qw_r       <= QUAT_ONE;
      qx_r       <= '0;
      qy_r       <= '0;
      qz_r       <= '0;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_QUAT_W:  qw_r       <= cfg_wdata[15:0];
        REG_QUAT_X:  qx_r       <= cfg_wdata[15:0];
        REG_QUAT_Y:  qy_r       <= cfg_wdata[15:0];
        REG_QUAT_Z:  qz_r       <= cfg_wdata[15:0];
        REG_TRANS_X: trans_r[0] <= cfg_wdata;
        REG_TRANS_Y: trans_r[1] <= cfg_wdata;
        REG_TRANS_Z: trans_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Rotation matrix from the quaternion, Q2.28, registered
  logic signed [31:0]      xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [R_W-1:0]   rot_nxt [9];
  logic signed [R_W-1:0]   rot_r [9];

  always_comb begin
    xx = qx_r * qx_r;
    yy = qy_r * qy_r;
    zz = qz_r * qz_r;
    xy = qx_r * qy_r;
    xz = qx_r * qz_r;
    yz = qy_r * qz_r;
    xw = qx_r * qw_r;
    yw = qy_r * qw_r;
    zw = qz_r * qw_r;
    rot_nxt[0] = R_W'(Q28_ONE) - ((R_W'(yy) + R_W'(zz)) <<< 1);
    rot_nxt[1] = (R_W'(xy) - R_W'(zw)) <<< 1;
    rot_nxt[2] = (R_W'(xz) + R_W'(yw)) <<< 1;
    rot_nxt[3] = (R_W'(xy) + R_W'(zw)) <<< 1;
    rot_nxt[4] = R_W'(Q28_ONE) - ((R_W'(xx) + R_W'(zz)) <<< 1);
    rot_nxt[5] = (R_W'(yz) - R_W'(xw)) <<< 1;
    rot_nxt[6] = (R_W'(xz) - R_W'(yw)) <<< 1;
    rot_nxt[7] = (R_W'(yz) + R_W'(xw)) <<< 1;
    rot_nxt[8] = R_W'(Q28_ONE) - ((R_W'(xx) + R_W'(yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      rot_r[k] <= rot_nxt[k];
    end
  end

  // Input transaction unpack
  color_t in_color;
  assign in_color.blue  = in_tdata[DEP_LO+23:DEP_LO+16];
  assign in_color.green = in_tdata[DEP_LO+31:DEP_LO+24];
  assign in_color.red   = in_tdata[DEP_LO+39:DEP_LO+32];

  tag_t                    bp_tag;
  logic signed [PC_W-1:0]  pc_x;
  logic signed [PC_W-1:0]  pc_y;
  logic signed [PC_W-1:0]  pc_z;

  dpwp_backproj #(
    .COL_BITS (COL_BITS),
    .ROW_BITS (ROW_BITS),
    .PC_W     (PC_W)
  ) u_backproj (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .col      (in_tdata[COL_BITS-1:0]),
    .row      (in_tdata[DEP_LO-1:COL_BITS]),
    .depth_mm (in_tdata[DEP_LO+15:DEP_LO]),
    .color    (in_color),
    .tag_o    (bp_tag),
    .pc_x     (pc_x),
    .pc_y     (pc_y),
    .pc_z     (pc_z)
  );

  tag_t                pose_tag;
  logic signed [31:0]  world [3];

  dpwp_pose #(
    .PC_W (PC_W)
  ) u_pose (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tag_i (bp_tag),
    .pc_x  (pc_x),
    .pc_y  (pc_y),
    .pc_z  (pc_z),
    .rot   (rot_r),
    .trans (trans_r),
    .tag_o (pose_tag),
    .world (world)
  );

  // Output transaction
  assign out_tvalid = pose_tag.valid;
  assign out_tdata  = {pose_tag.color.red, pose_tag.color.green, pose_tag.color.blue,
                       world[2], world[1], world[0]};

endmodule

`default_nettype wire
